### sv/spcm_pkg.sv
// Package: shared types, codes and constants of the stereo PCM continuity monitor.
package spcm_pkg;

    localparam int unsigned SAMPLE_W          = 16;
    localparam int unsigned FRAME_W           = 64;
    localparam int unsigned COUNT_W           = 64;
    localparam int unsigned INDEX_W           = 6;
    localparam int unsigned KIND_W            = 2;
    localparam int unsigned CFG_INDEX_W       = 2;
    localparam int unsigned CFG_DATA_W        = 16;
    localparam int unsigned NUM_THR           = 3;
    localparam int unsigned LOG_DEPTH_DEFAULT = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAIR = 2'd0,
        KIND_STAT = 2'd1,
        KIND_LOG  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_THR_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THR_MID  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THR_HIGH = 2'd2;

    localparam logic [SAMPLE_W-1:0] THR_LOW_RESET  = 16'd4096;
    localparam logic [SAMPLE_W-1:0] THR_MID_RESET  = 16'd8192;
    localparam logic [SAMPLE_W-1:0] THR_HIGH_RESET = 16'd16384;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE_POS = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE_NEG = 16'h8000;

    // Statistic numbers
    localparam logic [INDEX_W-1:0] STAT_FRAME_COUNT = 6'd0;
    localparam logic [INDEX_W-1:0] STAT_PAIR_COUNT  = 6'd1;
    localparam logic [INDEX_W-1:0] STAT_FULL_SCALE  = 6'd2;
    localparam logic [INDEX_W-1:0] STAT_STEP_COUNT  = 6'd3;
    localparam logic [INDEX_W-1:0] STAT_STEP_SUM    = 6'd4;
    localparam logic [INDEX_W-1:0] STAT_STEP_MAX    = 6'd5;
    localparam logic [INDEX_W-1:0] STAT_LARGE_LOW   = 6'd6;
    localparam logic [INDEX_W-1:0] STAT_LARGE_MID   = 6'd7;
    localparam logic [INDEX_W-1:0] STAT_LARGE_HIGH  = 6'd8;
    localparam logic [INDEX_W-1:0] STAT_EDGE_COUNT  = 6'd9;
    localparam logic [INDEX_W-1:0] STAT_EDGE_SUM    = 6'd10;
    localparam logic [INDEX_W-1:0] STAT_EDGE_MAX    = 6'd11;
    localparam logic [INDEX_W-1:0] STAT_EDGE_LOW    = 6'd12;
    localparam logic [INDEX_W-1:0] STAT_EDGE_MID    = 6'd13;
    localparam logic [INDEX_W-1:0] STAT_EDGE_HIGH   = 6'd14;
    localparam logic [INDEX_W-1:0] STAT_LOG_FILL    = 6'd15;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame;
        logic                channel;
        logic [SAMPLE_W-1:0] previous;
        logic [SAMPLE_W-1:0] current;
        logic [SAMPLE_W-1:0] delta;
    } log_entry_t;

    // Absolute step between two two's complement samples
    function automatic logic [SAMPLE_W-1:0] abs_step(input logic [SAMPLE_W-1:0] cur,
                                                     input logic [SAMPLE_W-1:0] prv);
        logic signed [SAMPLE_W:0] diff;
        diff = signed'({cur[SAMPLE_W-1], cur}) - signed'({prv[SAMPLE_W-1], prv});
        return diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    endfunction

endpackage

### sv/spcm_if.sv
// Interfaces: item and result channels of the stereo PCM continuity monitor.
interface spcm_item_if;
    logic                                 valid;
    logic                                 ready;
    logic [spcm_pkg::KIND_W-1:0]          kind;
    logic signed [spcm_pkg::SAMPLE_W-1:0] left_sample;
    logic signed [spcm_pkg::SAMPLE_W-1:0] right_sample;
    logic                                 frame_start;
    logic [spcm_pkg::FRAME_W-1:0]         frame_number;
    logic [spcm_pkg::INDEX_W-1:0]         index;

    modport source (output valid, kind, left_sample, right_sample, frame_start,
                    frame_number, index, input ready);
    modport sink   (input valid, kind, left_sample, right_sample, frame_start,
                    frame_number, index, output ready);
endinterface

interface spcm_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [spcm_pkg::COUNT_W-1:0]         stat_value;
    logic [spcm_pkg::FRAME_W-1:0]         event_frame;
    logic                                 event_channel;
    logic signed [spcm_pkg::SAMPLE_W-1:0] event_previous;
    logic signed [spcm_pkg::SAMPLE_W-1:0] event_current;
    logic [spcm_pkg::SAMPLE_W-1:0]        event_delta;
    logic                                 event_present;

    modport source (output valid, stat_value, event_frame, event_channel, event_previous,
                    event_current, event_delta, event_present, input ready);
    modport sink   (input valid, stat_value, event_frame, event_channel, event_previous,
                    event_current, event_delta, event_present, output ready);
endinterface

### sv/stereo_pcm_continuity_monitor_core.sv
// Top level: stereo PCM continuity monitor with statistics and boundary event log.
//
//   channel  | dir | handshake        | word
//   ---------+-----+------------------+-------------------------------------------
//   item     | in  | valid/ready      | kind, samples, frame_start, frame_number, index
//   result   | out | valid/ready      | stat_value and event log fields
//   cfg      | in  | cfg_write only   | cfg_index, cfg_data (thresholds)
//
// A read passes from the work stage into the output register, so reads and most pairs
// run one per cycle unless the output stalls. A pair whose left and right boundary steps
// both need logging takes a second phase, as the log memory has a single write port.
// Reset is asynchronous, clears all statistics and the log fill count and loads the
// threshold defaults; the log memory needs no clearing. A stalled output holds the output
// register and a read in the work stage; the input is taken while the stage is free.
module stereo_pcm_continuity_monitor_core #(
    parameter int unsigned LOG_DEPTH = spcm_pkg::LOG_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    spcm_item_if.sink                           item,
    spcm_result_if.source                       result,
    input  logic                                cfg_write,
    input  logic [spcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [spcm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int unsigned FW    = $clog2(LOG_DEPTH + 1);
    localparam int unsigned CMP_W = (FW > spcm_pkg::INDEX_W) ? FW : spcm_pkg::INDEX_W;
    localparam int unsigned SW    = spcm_pkg::SAMPLE_W;
    localparam int unsigned CW    = spcm_pkg::COUNT_W;
    localparam int unsigned NT    = spcm_pkg::NUM_THR;

    // Thresholds
    logic [SW-1:0] thr_reg [NT];

    // Work stage
    logic                             s1_valid_reg;
    spcm_pkg::kind_t                  s1_kind_reg;
    logic [SW-1:0]                    s1_left_reg;
    logic [SW-1:0]                    s1_right_reg;
    logic                             s1_start_reg;
    logic [spcm_pkg::FRAME_W-1:0]     s1_frame_reg;
    logic [spcm_pkg::INDEX_W-1:0]     s1_index_reg;
    logic                             phase_reg;
    logic                             phase_next;

    // Output register
    logic                             s2_valid_reg;
    logic                             s2_present_reg;
    logic [CW-1:0]                    s2_stat_reg;

    // Statistics
    logic [SW-1:0]   last_sample_reg [2];
    logic            last_valid_reg  [2];
    logic [CW-1:0]   frame_cnt_reg;
    logic [CW-1:0]   pair_cnt_reg;
    logic [CW-1:0]   full_scale_reg;
    logic [CW-1:0]   step_cnt_reg;
    logic [CW-1:0]   step_sum_reg;
    logic [SW-1:0]   step_max_reg;
    logic [CW-1:0]   large_cnt_reg [NT];
    logic [CW-1:0]   edge_cnt_reg;
    logic [CW-1:0]   edge_sum_reg;
    logic [SW-1:0]   edge_max_reg;
    logic [CW-1:0]   edge_large_reg [NT];
    logic [FW-1:0]   log_fill_reg;

    // Event log memory
    spcm_pkg::log_entry_t log_mem [LOG_DEPTH];
    spcm_pkg::log_entry_t log_q;

    // Work stage logic
    logic            s1_is_pair;
    logic            s1_is_read;
    logic            out_free;
    logic            s1_done;
    logic [SW-1:0]   cur_smp   [2];
    logic [SW-1:0]   step_d    [2];
    logic [SW-1:0]   step_m    [2];
    logic            step_v    [2];
    logic            full_sc   [2];
    logic            log_want  [2];
    logic            fill_room;
    logic            two_phase;
    logic            wr_en;
    logic            wr_right;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic            rd_present;
    spcm_pkg::log_entry_t wr_entry;
    logic [1:0]      step_inc;
    logic [SW:0]     sum_inc;
    logic [SW-1:0]   max_pair;
    logic [1:0]      large_inc [NT];
    logic [1:0]      fs_inc;
    logic [CW-1:0]   stat_sel;

    assign s1_is_pair = s1_valid_reg && (s1_kind_reg == spcm_pkg::KIND_PAIR);
    assign s1_is_read = s1_valid_reg &&
                        ((s1_kind_reg == spcm_pkg::KIND_STAT) ||
                         (s1_kind_reg == spcm_pkg::KIND_LOG));
    assign out_free   = !s2_valid_reg || result.ready;
    assign fill_room  = (log_fill_reg != FW'(LOG_DEPTH));

    // Per-channel steps against the last sample held
    always_comb
    begin
        cur_smp[0] = s1_left_reg;
        cur_smp[1] = s1_right_reg;
        for (int ch = 0; ch < 2; ch++)
        begin
            step_d[ch]   = spcm_pkg::abs_step(cur_smp[ch], last_sample_reg[ch]);
            step_v[ch]   = last_valid_reg[ch];
            step_m[ch]   = step_v[ch] ? step_d[ch] : '0;
            full_sc[ch]  = (cur_smp[ch] == spcm_pkg::FULL_SCALE_POS) ||
                           (cur_smp[ch] == spcm_pkg::FULL_SCALE_NEG);
            log_want[ch] = s1_start_reg && step_v[ch] &&
                           (step_d[ch] >= thr_reg[spcm_pkg::CFG_THR_MID]);
        end
    end

    // Both channels logging: left goes in the first phase, right in the second
    assign two_phase = log_want[0] && log_want[1] && fill_room;

    assign s1_done = s1_valid_reg &&
                     (s1_is_read ? out_free : (!(s1_is_pair && two_phase) || phase_reg));

    assign item.ready = !s1_valid_reg || s1_done;

    always_comb
    begin
        phase_next = phase_reg;
        if (s1_done)
        begin
            phase_next = 1'b0;
        end
        else if (s1_is_pair && two_phase)
        begin
            phase_next = 1'b1;
        end
    end

    // Log write selection
    assign wr_en    = s1_is_pair && fill_room &&
                      (phase_reg ? log_want[1] : (log_want[0] || log_want[1]));
    assign wr_right = phase_reg || !log_want[0];
    assign wr_addr  = AW'(log_fill_reg);

    always_comb
    begin
        wr_entry.frame    = s1_frame_reg;
        wr_entry.channel  = wr_right;
        wr_entry.previous = wr_right ? last_sample_reg[1] : last_sample_reg[0];
        wr_entry.current  = wr_right ? s1_right_reg : s1_left_reg;
        wr_entry.delta    = wr_right ? step_d[1] : step_d[0];
    end

    // Statistic increments of one pair
    always_comb
    begin
        step_inc = {1'b0, step_v[0]} + {1'b0, step_v[1]};
        sum_inc  = {1'b0, step_m[0]} + {1'b0, step_m[1]};
        fs_inc   = {1'b0, full_sc[0]} + {1'b0, full_sc[1]};
        max_pair = (step_m[0] > step_m[1]) ? step_m[0] : step_m[1];
        for (int t = 0; t < NT; t++)
        begin
            large_inc[t] = {1'b0, step_v[0] && (step_d[0] >= thr_reg[t])} +
                           {1'b0, step_v[1] && (step_d[1] >= thr_reg[t])};
        end
    end

    // Statistic read
    always_comb
    begin
        case (s1_index_reg)
            spcm_pkg::STAT_FRAME_COUNT: stat_sel = frame_cnt_reg;
            spcm_pkg::STAT_PAIR_COUNT:  stat_sel = pair_cnt_reg;
            spcm_pkg::STAT_FULL_SCALE:  stat_sel = full_scale_reg;
            spcm_pkg::STAT_STEP_COUNT:  stat_sel = step_cnt_reg;
            spcm_pkg::STAT_STEP_SUM:    stat_sel = step_sum_reg;
            spcm_pkg::STAT_STEP_MAX:    stat_sel = CW'(step_max_reg);
            spcm_pkg::STAT_LARGE_LOW:   stat_sel = large_cnt_reg[spcm_pkg::CFG_THR_LOW];
            spcm_pkg::STAT_LARGE_MID:   stat_sel = large_cnt_reg[spcm_pkg::CFG_THR_MID];
            spcm_pkg::STAT_LARGE_HIGH:  stat_sel = large_cnt_reg[spcm_pkg::CFG_THR_HIGH];
            spcm_pkg::STAT_EDGE_COUNT:  stat_sel = edge_cnt_reg;
            spcm_pkg::STAT_EDGE_SUM:    stat_sel = edge_sum_reg;
            spcm_pkg::STAT_EDGE_MAX:    stat_sel = CW'(edge_max_reg);
            spcm_pkg::STAT_EDGE_LOW:    stat_sel = edge_large_reg[spcm_pkg::CFG_THR_LOW];
            spcm_pkg::STAT_EDGE_MID:    stat_sel = edge_large_reg[spcm_pkg::CFG_THR_MID];
            spcm_pkg::STAT_EDGE_HIGH:   stat_sel = edge_large_reg[spcm_pkg::CFG_THR_HIGH];
            spcm_pkg::STAT_LOG_FILL:    stat_sel = CW'(log_fill_reg);
            default:                    stat_sel = '0;
        endcase
    end

    assign rd_addr    = AW'(s1_index_reg);
    assign rd_present = (s1_kind_reg == spcm_pkg::KIND_LOG) &&
                        (CMP_W'(s1_index_reg) < CMP_W'(log_fill_reg));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg[spcm_pkg::CFG_THR_LOW]  <= spcm_pkg::THR_LOW_RESET;
            thr_reg[spcm_pkg::CFG_THR_MID]  <= spcm_pkg::THR_MID_RESET;
            thr_reg[spcm_pkg::CFG_THR_HIGH] <= spcm_pkg::THR_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                spcm_pkg::CFG_THR_LOW:  thr_reg[spcm_pkg::CFG_THR_LOW]  <= cfg_data;
                spcm_pkg::CFG_THR_MID:  thr_reg[spcm_pkg::CFG_THR_MID]  <= cfg_data;
                spcm_pkg::CFG_THR_HIGH: thr_reg[spcm_pkg::CFG_THR_HIGH] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Work stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (item.ready)
            begin
                s1_valid_reg <= item.valid;
            end
        end
    end

    // Work stage payload: take a word whenever the stage frees
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_kind_reg  <= spcm_pkg::kind_t'(item.kind);
            s1_left_reg  <= item.left_sample;
            s1_right_reg <= item.right_sample;
            s1_start_reg <= item.frame_start;
            s1_frame_reg <= item.frame_number;
            s1_index_reg <= item.index;
        end
    end

    // Statistics update, once per pair as it leaves the work stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg[0] <= '0;
            last_sample_reg[1] <= '0;
            last_valid_reg[0]  <= 1'b0;
            last_valid_reg[1]  <= 1'b0;
            frame_cnt_reg      <= '0;
            pair_cnt_reg       <= '0;
            full_scale_reg     <= '0;
            step_cnt_reg       <= '0;
            step_sum_reg       <= '0;
            step_max_reg       <= '0;
            edge_cnt_reg       <= '0;
            edge_sum_reg       <= '0;
            edge_max_reg       <= '0;
            for (int t = 0; t < NT; t++)
            begin
                large_cnt_reg[t]  <= '0;
                edge_large_reg[t] <= '0;
            end
        end
        else if (s1_is_pair && s1_done)
        begin
            last_sample_reg[0] <= s1_left_reg;
            last_sample_reg[1] <= s1_right_reg;
            last_valid_reg[0]  <= 1'b1;
            last_valid_reg[1]  <= 1'b1;
            frame_cnt_reg      <= frame_cnt_reg + CW'(s1_start_reg);
            pair_cnt_reg       <= pair_cnt_reg + CW'(1);
            full_scale_reg     <= full_scale_reg + CW'(fs_inc);
            step_cnt_reg       <= step_cnt_reg + CW'(step_inc);
            step_sum_reg       <= step_sum_reg + CW'(sum_inc);
            if (max_pair > step_max_reg)
            begin
                step_max_reg <= max_pair;
            end
            for (int t = 0; t < NT; t++)
            begin
                large_cnt_reg[t] <= large_cnt_reg[t] + CW'(large_inc[t]);
            end
            if (s1_start_reg)
            begin
                edge_cnt_reg <= edge_cnt_reg + CW'(step_inc);
                edge_sum_reg <= edge_sum_reg + CW'(sum_inc);
                if (max_pair > edge_max_reg)
                begin
                    edge_max_reg <= max_pair;
                end
                for (int t = 0; t < NT; t++)
                begin
                    edge_large_reg[t] <= edge_large_reg[t] + CW'(large_inc[t]);
                end
            end
        end
    end

    // Log fill count: advance on every entry written, saturating by the room check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_fill_reg <= '0;
        end
        else if (wr_en)
        begin
            log_fill_reg <= log_fill_reg + FW'(1);
        end
    end

    // Log memory: one write port, one registered read port. A read in the work stage
    // never meets a write, as writes come only from a pair in the same stage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            log_mem[wr_addr] <= wr_entry;
        end
        if (s1_done && rd_present)
        begin
            log_q <= log_mem[rd_addr];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_done && s1_is_read)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_done && s1_is_read)
        begin
            s2_present_reg <= rd_present;
            s2_stat_reg    <= (s1_kind_reg == spcm_pkg::KIND_STAT) ? stat_sel : '0;
        end
    end

    // Drive the result word; log fields read as zero unless the entry was present
    assign result.valid          = s2_valid_reg;
    assign result.stat_value     = s2_stat_reg;
    assign result.event_present  = s2_present_reg;
    assign result.event_frame    = s2_present_reg ? log_q.frame : '0;
    assign result.event_channel  = s2_present_reg ? log_q.channel : 1'b0;
    assign result.event_previous = s2_present_reg ? log_q.previous : '0;
    assign result.event_current  = s2_present_reg ? log_q.current : '0;
    assign result.event_delta    = s2_present_reg ? log_q.delta : '0;

endmodule
